// ===== hw/rtl/x86mov_pkg.sv =====
package x86mov_pkg;

  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [3:0] OPC_IMM_REG = 4'b1011;
  localparam logic [6:0] OPC_IMM_RM  = 7'b1100011;
  localparam logic [5:0] OPC_RM_REG  = 6'b100010;

  localparam logic [1:0] FORM_IMM_REG = 2'd0;
  localparam logic [1:0] FORM_RM_REG  = 2'd1;
  localparam logic [1:0] FORM_IMM_RM  = 2'd2;

  localparam logic [1:0] MOD_MEM_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8      = 2'd1;
  localparam logic [1:0] MOD_DISP16     = 2'd2;
  localparam logic [2:0] RM_DIRECT      = 3'd6;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_MODRM   = 3'd1,
    PH_DISP_LO = 3'd2,
    PH_DISP_HI = 3'd3,
    PH_IMM_LO  = 3'd4,
    PH_IMM_HI  = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [7:0]  imm_lo;
  } state_t;

  typedef struct packed {
    logic [1:0]         form;
    logic               wide;
    logic               to_register;
    logic [1:0]         mode_bits;
    logic [2:0]         reg_code;
    logic [2:0]         rm_code;
    logic               direct_address;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
  } res_t;

  function automatic logic [1:0] form_of(input logic [7:0] op);
    logic [1:0] f;
    if (op[7:4] == OPC_IMM_REG) begin
      f = FORM_IMM_REG;
    end else if (op[7:1] == OPC_IMM_RM) begin
      f = FORM_IMM_RM;
    end else begin
      f = FORM_RM_REG;
    end
    return f;
  endfunction

  function automatic logic wide_of(input logic [7:0] op);
    return (form_of(op) == FORM_IMM_REG) ? op[3] : op[0];
  endfunction

  function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
    logic [1:0] n;
    case (modrm[7:6])
      MOD_DISP8:      n = 2'd1;
      MOD_DISP16:     n = 2'd2;
      MOD_MEM_NODISP: n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
      default:        n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

endpackage

// ===== hw/rtl/x86_mov_instruction_decoder.sv =====
// a code byte is held in the byte register, and its result is registered in the result register that drives out_tvalid
// throughput: one code byte per cycle while in_tready is high, set by the single-pass decode between the byte
// register and the result register
// in_tready drops only while both the byte register and the result register are full
// reset (rst_n low, synchronous) empties both registers and returns to the opcode phase
module x86_mov_instruction_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // code_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [x86mov_pkg::OUT_DATA_W-1:0] out_tdata, // wide, to_register, mode_bits,
                                                       // reg_code, rm_code, direct_address,
                                                       // displacement, immediate, zero pad
  output logic [1:0]                        out_tuser  // form
);
  import x86mov_pkg::*;

  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  state_t                state_r;
  state_t                state_nxt;
  logic                  res_vld;
  res_t                  res;
  logic                  out_vld_r;
  res_t                  out_res_r;
  logic                  consume;

  assign consume   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || consume;

  x86mov_dec u_dec (
    .state     (state_r),
    .code_byte (in_byte_r),
    .state_nxt (state_nxt),
    .res_vld   (res_vld),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_OPCODE, opcode: 8'h00, modrm: 8'h00, disp: 16'h0000,
                   imm_lo: 8'h00};
    end else if (consume) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (consume) begin
      out_vld_r <= res_vld;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.form;
  assign out_tdata  = {5'b00000, out_res_r.immediate, out_res_r.displacement,
                       out_res_r.direct_address, out_res_r.rm_code, out_res_r.reg_code,
                       out_res_r.mode_bits, out_res_r.to_register, out_res_r.wide};

  // stall only when both register stages hold a byte and a result
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && out_vld_r))
    else $error("input stalled with a free register stage");

  a_imm_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.form == FORM_IMM_REG) |->
    (out_res_r.mode_bits == MOD_MEM_NODISP && out_res_r.rm_code == 3'd0 &&
     out_res_r.displacement == 16'sh0000 && !out_res_r.direct_address))
    else $error("immediate to register transaction carries address fields");

  a_rm_reg_no_imm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.form == FORM_RM_REG) |-> (out_res_r.immediate == 16'sh0000))
    else $error("register/memory transaction carries immediate data");

  a_direct_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.direct_address) |->
    (out_res_r.mode_bits == MOD_MEM_NODISP && out_res_r.rm_code == RM_DIRECT))
    else $error("direct address flag without mod 0 and r/m 6");

endmodule

// ===== hw/rtl/x86mov_dec.sv =====
module x86mov_dec (
  input  x86mov_pkg::state_t state,
  input  logic [7:0]         code_byte,
  output x86mov_pkg::state_t state_nxt,
  output logic               res_vld,
  output x86mov_pkg::res_t   res
);
  import x86mov_pkg::*;

  logic [1:0] cur_form;
  logic [1:0] nxt_form;

  assign cur_form = form_of(state.opcode);
  assign nxt_form = form_of(state_nxt.opcode);

  // next state and latches
  always_comb begin
    state_nxt = state;
    case (state.phase)
      PH_MODRM: begin
        state_nxt.modrm = code_byte;
        if (disp_bytes(code_byte) != 2'd0) begin
          state_nxt.phase = PH_DISP_LO;
        end else begin
          state_nxt.phase = (cur_form == FORM_IMM_RM) ? PH_IMM_LO : PH_OPCODE;
        end
      end
      PH_DISP_LO: begin
        if (disp_bytes(state.modrm) == 2'd2) begin
          state_nxt.disp  = {8'h00, code_byte};
          state_nxt.phase = PH_DISP_HI;
        end else begin
          state_nxt.disp  = sext8(code_byte);
          state_nxt.phase = (cur_form == FORM_IMM_RM) ? PH_IMM_LO : PH_OPCODE;
        end
      end
      PH_DISP_HI: begin
        state_nxt.disp  = {code_byte, state.disp[7:0]};
        state_nxt.phase = (cur_form == FORM_IMM_RM) ? PH_IMM_LO : PH_OPCODE;
      end
      PH_IMM_LO: begin
        state_nxt.imm_lo = code_byte;
        state_nxt.phase  = wide_of(state.opcode) ? PH_IMM_HI : PH_OPCODE;
      end
      PH_IMM_HI: begin
        state_nxt.phase = PH_OPCODE;
      end
      default: begin
        if (code_byte[7:4] == OPC_IMM_REG || code_byte[7:1] == OPC_IMM_RM ||
            code_byte[7:2] == OPC_RM_REG) begin
          state_nxt.opcode = code_byte;
          state_nxt.modrm  = 8'h00;
          state_nxt.disp   = 16'h0000;
          state_nxt.imm_lo = 8'h00;
          state_nxt.phase  = (code_byte[7:4] == OPC_IMM_REG) ? PH_IMM_LO : PH_MODRM;
        end else begin
          state_nxt.phase = PH_OPCODE;
        end
      end
    endcase
  end

  // result of the last byte of an instruction
  always_comb begin
    res_vld       = 1'b0;
    res           = '0;
    res.immediate = 16'sh0000;
    case (state.phase)
      PH_MODRM: begin
        res_vld = (disp_bytes(code_byte) == 2'd0) && (cur_form != FORM_IMM_RM);
      end
      PH_DISP_LO: begin
        res_vld = (disp_bytes(state.modrm) != 2'd2) && (cur_form != FORM_IMM_RM);
      end
      PH_DISP_HI: begin
        res_vld = (cur_form != FORM_IMM_RM);
      end
      PH_IMM_LO: begin
        res_vld       = !wide_of(state.opcode);
        res.immediate = sext8(code_byte);
      end
      PH_IMM_HI: begin
        res_vld       = 1'b1;
        res.immediate = {code_byte, state.imm_lo};
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase

    res.form = nxt_form;
    res.wide = wide_of(state_nxt.opcode);
    if (nxt_form == FORM_IMM_REG) begin
      res.reg_code = state_nxt.opcode[2:0];
    end else begin
      res.to_register    = (nxt_form == FORM_RM_REG) ? state_nxt.opcode[1] : 1'b0;
      res.mode_bits      = state_nxt.modrm[7:6];
      res.reg_code       = state_nxt.modrm[5:3];
      res.rm_code        = state_nxt.modrm[2:0];
      res.direct_address = (state_nxt.modrm[7:6] == MOD_MEM_NODISP) &&
                           (state_nxt.modrm[2:0] == RM_DIRECT);
      res.displacement   = state_nxt.disp;
    end
  end

endmodule
